>>> rtl/core/magnetometer_extremes_bias_tracker_assert.svh
// Assertion macros for the magnetometer extremes bias tracker.
// Included by the top-level RTL file, which checks its own logic; no other dependencies.
`ifndef MAGNETOMETER_EXTREMES_BIAS_TRACKER_ASSERT_SVH
`define MAGNETOMETER_EXTREMES_BIAS_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MEBT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MEBT_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MEBT_ASSERT(label, clk, rst_n, prop, msg)
`define MEBT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/mebt_pkg.sv
// Package for the magnetometer extremes bias tracker: sizes, beat types and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mebt_pkg;

  localparam int unsigned LIST_DEPTH = 40;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MID_IDX    = LIST_DEPTH / 2;
  localparam int unsigned AXES       = 3;

  localparam logic ACT_CLEAR  = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    action;
    sample_t sample_x;
    sample_t sample_y;
    sample_t sample_z;
  } in_beat_t;

  typedef struct packed {
    sample_t bias_x;
    sample_t bias_y;
    sample_t bias_z;
  } out_beat_t;

  typedef struct packed {
    logic    beyond;
    sample_t value;
  } link_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } list_ctrl_t;

  // Sum of two samples halved with truncation toward zero.
  function automatic sample_t half_sum(sample_t a, sample_t b);
    logic signed [SAMPLE_W:0] s;
    logic signed [SAMPLE_W:0] r;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    r = s + {{SAMPLE_W{1'b0}}, s[SAMPLE_W] & s[0]};
    return r[SAMPLE_W:1];
  endfunction

endpackage

>>> rtl/core/magnetometer_extremes_bias_tracker.sv
// Top level of the magnetometer extremes bias tracker: six cell chains and the result stage.
// Depends on mebt_pkg, mebt_list and the assertion macro header.
//
//   Channel   Handshake                  Beat
//   input     in_valid_i / in_ready_o    in_data_i  (in_beat_t)
//   output    out_valid_o / out_ready_i  out_data_o (out_beat_t)
//
// One beat is accepted per cycle while in_ready_o is high.
// All cells of a list compare and shift in the cycle of acceptance, and the middle
// entries are summed and halved into the output register once the output can advance.
// Reset clears all list entries to zero and empties the pipeline.
// A stalled output holds its beat; the input stalls only while a computed result
// has nowhere to go.
`timescale 1ns / 1ps
`include "magnetometer_extremes_bias_tracker_assert.svh"

module magnetometer_extremes_bias_tracker import mebt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic       accept;
  logic       advance;
  list_ctrl_t ctrl;
  logic       pend_q, pend_d;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;
  sample_t    samples [AXES];
  sample_t    max_mid [AXES];
  sample_t    min_mid [AXES];

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance || !pend_q;
  assign accept     = in_valid_i && in_ready_o;

  assign ctrl.clear  = accept && (in_data_i.action == ACT_CLEAR);
  assign ctrl.insert = accept && (in_data_i.action == ACT_INSERT);

  assign samples[0] = in_data_i.sample_x;
  assign samples[1] = in_data_i.sample_y;
  assign samples[2] = in_data_i.sample_z;

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    mebt_list u_max (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .is_max_i (1'b1),
      .sample_i (samples[a]),
      .mid_o    (max_mid[a])
    );
    mebt_list u_min (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .is_max_i (1'b0),
      .sample_i (samples[a]),
      .mid_o    (min_mid[a])
    );
  end

  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pend_q && advance) begin
      out_valid_d = 1'b1;
      out_d.bias_x = half_sum(max_mid[0], min_mid[0]);
      out_d.bias_y = half_sum(max_mid[1], min_mid[1]);
      out_d.bias_z = half_sum(max_mid[2], min_mid[2]);
      pend_d = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MEBT_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (pend_q && !advance) |-> !in_ready_o, "input accepted while result stage is blocked")
  `MEBT_ASSERT(a_clear_zeroes_mid, clk_i, rst_ni, ctrl.clear |=> (max_mid[0] == '0 && min_mid[0] == '0 && max_mid[1] == '0 && min_mid[1] == '0 && max_mid[2] == '0 && min_mid[2] == '0), "middle entries not zero after clear")
  `MEBT_ASSERT(a_mid_sign, clk_i, rst_ni, (max_mid[0] >= 0 && min_mid[0] <= 0 && max_mid[1] >= 0 && min_mid[1] <= 0 && max_mid[2] >= 0 && min_mid[2] <= 0), "middle extreme has the wrong sign")
  `MEBT_ASSERT(a_pend_to_out, clk_i, rst_ni, (pend_q && advance) |=> out_valid_o, "computed result not presented")

endmodule

>>> rtl/core/mebt_cell.sv
// One entry of a sorted extremes list, with its compare and shift logic.
// Depends on mebt_pkg.
`timescale 1ns / 1ps

module mebt_cell import mebt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  list_ctrl_t ctrl_i,
  input  logic       is_max_i,
  input  sample_t    sample_i,
  input  link_t      prev_i,
  output link_t      link_o
);

  sample_t val_q, val_d;
  logic    beyond;

  assign beyond = is_max_i ? (sample_i > val_q) : (sample_i < val_q);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.clear) begin
      val_d = '0;
    end else if (ctrl_i.insert && beyond) begin
      val_d = prev_i.beyond ? prev_i.value : sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign link_o = '{beyond: beyond, value: val_q};

endmodule

>>> rtl/core/mebt_list.sv
// A chain of cells that holds one sorted list of extreme samples.
// Depends on mebt_pkg and mebt_cell.
`timescale 1ns / 1ps

module mebt_list import mebt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  list_ctrl_t ctrl_i,
  input  logic       is_max_i,
  input  sample_t    sample_i,
  output sample_t    mid_o
);

  link_t links [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    link_t prev;
    if (i == 0) begin : g_head
      assign prev = '{beyond: 1'b0, value: '0};
    end else begin : g_body
      assign prev = links[i-1];
    end
    mebt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_i),
      .is_max_i (is_max_i),
      .sample_i (sample_i),
      .prev_i   (prev),
      .link_o   (links[i])
    );
  end

  assign mid_o = links[MID_IDX].value;

endmodule

>>> test/magnetometer_extremes_bias_tracker_tb.sv
// Testbench for magnetometer_extremes_bias_tracker: a directed table and then random
// sample runs, each result beat checked against table values or a local model of the extreme lists.
// Depends on mebt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module magnetometer_extremes_bias_tracker_tb;
  import mebt_pkg::*;

  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t offsets;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  sample_t   peak_hi [AXES][LIST_DEPTH];
  sample_t   peak_lo [AXES][LIST_DEPTH];
  out_beat_t pending_offsets[$];
  out_beat_t want;
  string     field_names [AXES] = '{"bias_x", "bias_y", "bias_z"};

  logic steady;
  int   fails;
  int   beats_sent;
  int   clears_sent;
  int   beats_checked;
  int   nonzero_seen;
  int   runs;

  magnetometer_extremes_bias_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[magnetometer_extremes_bias_tracker] ERROR");
    $finish;
  end

  function automatic void clear_peaks();
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        peak_hi[a][k] = '0;
        peak_lo[a][k] = '0;
      end
    end
  endfunction

  // Descending list of largest samples and ascending list of smallest; a newcomer goes
  // after its equals and pushes the tail entry out.
  function automatic void track_sample(int axis, sample_t v);
    int pos;
    if (v > peak_hi[axis][LIST_DEPTH-1]) begin
      pos = 0;
      while (!(v > peak_hi[axis][pos])) pos++;
      for (int k = LIST_DEPTH - 1; k > pos; k--) peak_hi[axis][k] = peak_hi[axis][k-1];
      peak_hi[axis][pos] = v;
    end
    if (v < peak_lo[axis][LIST_DEPTH-1]) begin
      pos = 0;
      while (!(v < peak_lo[axis][pos])) pos++;
      for (int k = LIST_DEPTH - 1; k > pos; k--) peak_lo[axis][k] = peak_lo[axis][k-1];
      peak_lo[axis][pos] = v;
    end
  endfunction

  function automatic out_beat_t next_offsets(in_beat_t b);
    out_beat_t r;
    int        s;
    if (b.action == ACT_CLEAR) begin
      clear_peaks();
    end else begin
      for (int a = 0; a < AXES; a++) track_sample(a, sample_t'(b[(2-a)*SAMPLE_W +: SAMPLE_W]));
    end
    for (int a = 0; a < AXES; a++) begin
      s = int'(peak_hi[a][MID_IDX]) + int'(peak_lo[a][MID_IDX]);
      r[(2-a)*SAMPLE_W +: SAMPLE_W] = sample_t'(s / 2);
    end
    return r;
  endfunction

  function automatic stim_row_t make_row(logic act, int x, int y, int z,
                                         logic typed, int bx, int by, int bz);
    stim_row_t r;
    r.beat.action    = act;
    r.beat.sample_x  = sample_t'(x);
    r.beat.sample_y  = sample_t'(y);
    r.beat.sample_z  = sample_t'(z);
    r.typed          = typed;
    r.offsets.bias_x = sample_t'(bx);
    r.offsets.bias_y = sample_t'(by);
    r.offsets.bias_z = sample_t'(bz);
    return r;
  endfunction

  function automatic sample_t pick_sample(int style);
    int s;
    s = (style == 3) ? $urandom_range(0, 2) : style;
    case (s)
      0: return sample_t'($urandom_range(0, 65535));
      1: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: begin
        if ($urandom_range(0, 1) == 0) return sample_t'(32767 - int'($urandom_range(0, 40)));
        return sample_t'(-32768 + int'($urandom_range(0, 40)));
      end
    endcase
  endfunction

  task automatic send_beat(in_beat_t b, logic typed, out_beat_t typed_offsets);
    int        gap;
    out_beat_t model;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    model = next_offsets(b);
    pending_offsets.push_back(typed ? typed_offsets : model);
    beats_sent++;
    if (b.action == ACT_CLEAR) clears_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_offsets.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_offsets.size() == 0) begin
        $error("Result beat %h arrived with no expectation waiting.", out_data_o);
        fails++;
      end else begin
        want = pending_offsets.pop_front();
        beats_checked++;
        if (out_data_o != '0) nonzero_seen++;
        for (int a = 0; a < AXES; a++) begin
          if (out_data_o[(2-a)*SAMPLE_W +: SAMPLE_W] !== want[(2-a)*SAMPLE_W +: SAMPLE_W]) begin
            $error("%s: expected %0d, actual %0d", field_names[a],
                   sample_t'(want[(2-a)*SAMPLE_W +: SAMPLE_W]),
                   sample_t'(out_data_o[(2-a)*SAMPLE_W +: SAMPLE_W]));
            fails++;
          end
        end
      end
    end
  end

  initial begin
    stim_row_t plan[$];
    in_beat_t  cmd;
    int        style;
    int        run_len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    steady      = 1'b0;
    fails       = 0;
    beats_sent  = 0;
    clears_sent = 0;
    beats_checked = 0;
    nonzero_seen  = 0;
    runs          = 0;
    clear_peaks();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero sample equals the tail and is not taken; single extremes leave the middle
    // entries at zero; a clear ignores its samples. Then 21 ramps reach the middle entry.
    plan.push_back(make_row(ACT_INSERT, 0, 0, 0, 1'b1, 0, 0, 0));
    plan.push_back(make_row(ACT_INSERT, 32767, -32768, 1, 1'b1, 0, 0, 0));
    plan.push_back(make_row(ACT_INSERT, -32768, 32767, 32767, 1'b1, 0, 0, 0));
    plan.push_back(make_row(ACT_CLEAR, 21845, -21846, -1, 1'b1, 0, 0, 0));
    for (int k = 1; k <= 21; k++) begin
      plan.push_back(make_row(ACT_INSERT, 1000 * k, -1000 * k,
                              (k % 2) ? 7 * k : -7 * k, 1'b0, 0, 0, 0));
    end
    foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].offsets);
    hold_until_drained();

    while (beats_sent < 525) begin
      style   = $urandom_range(0, 3);
      steady  = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(20, 70);
      if ($urandom_range(0, 9) != 0) begin
        cmd.action   = ACT_CLEAR;
        cmd.sample_x = pick_sample(0);
        cmd.sample_y = pick_sample(0);
        cmd.sample_z = pick_sample(0);
        send_beat(cmd, 1'b0, '0);
      end
      for (int i = 0; i < run_len; i++) begin
        cmd.action   = ($urandom_range(0, 29) == 0) ? ACT_CLEAR : ACT_INSERT;
        cmd.sample_x = pick_sample(style);
        cmd.sample_y = pick_sample(style);
        cmd.sample_z = pick_sample(style);
        send_beat(cmd, 1'b0, '0);
      end
      runs++;
      if ($urandom_range(0, 2) == 0) hold_until_drained();
    end

    in_valid_i <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d beats (%0d clears) over %0d random runs after the directed table.",
             beats_sent, clears_sent, runs);
    $display("Checked %0d result beats, %0d of them with a nonzero offset.",
             beats_checked, nonzero_seen);
    if (fails == 0) begin
      $display("[magnetometer_extremes_bias_tracker] OK");
    end else begin
      $display("[magnetometer_extremes_bias_tracker] ERROR");
    end
    $finish;
  end

endmodule

>>> magnetometer_extremes_bias_tracker.f
+incdir+rtl/core
rtl/core/mebt_pkg.sv
rtl/core/mebt_cell.sv
rtl/core/mebt_list.sv
rtl/core/magnetometer_extremes_bias_tracker.sv
test/magnetometer_extremes_bias_tracker_tb.sv
